// ===== src/tcpc_pkg.sv =====
package tcpc_pkg;

  localparam int unsigned CountWidthDefault = 16;
  localparam int unsigned FieldWidth        = 16;
  localparam int unsigned ApbAddrWidth      = 5;
  localparam int unsigned ApbDataWidth      = 32;
  localparam int unsigned InDataWidth       = 8;
  localparam int unsigned InUserWidth       = 2;
  localparam int unsigned OutDataWidth      = 56;

  typedef enum logic [1:0] {
    OP_TICK        = 2'd0,
    OP_TRIGGER     = 2'd1,
    OP_CLK_DISABLE = 2'd2,
    OP_CLK_ENABLE  = 2'd3
  } op_t;

  localparam logic [1:0] MODE_UP          = 2'd0;
  localparam logic [1:0] MODE_UPDOWN      = 2'd1;
  localparam logic [1:0] MODE_CAPTURE     = 2'd2;
  localparam logic [1:0] MODE_CAPTURE_ALT = 2'd3;

  localparam logic [2:0] REG_MODE          = 3'd0;
  localparam logic [2:0] REG_PERIOD_TOP    = 3'd1;
  localparam logic [2:0] REG_COMPARE_A     = 3'd2;
  localparam logic [2:0] REG_COMPARE_B     = 3'd3;
  localparam logic [2:0] REG_ONE_SHOT      = 3'd4;
  localparam logic [2:0] REG_OUTPUT_ENABLE = 3'd5;

  localparam logic [1:0]  RESET_MODE       = MODE_UP;
  localparam logic [15:0] RESET_PERIOD_TOP = 16'hFFFF;

endpackage

// ===== src/timer_counter_pwm_capture_channel.sv =====
// One 16-bit timer-counter channel with waveform and capture modes.
// Input stream: each beat is a counter clock tick, a software trigger, a clock
// disable or a clock enable (s_tuser), together with the sampled capture pin
// level (s_tdata bit 0). Every accepted beat produces exactly one result beat
// on the output stream carrying the count, both waveform levels, the period
// match flag, the captured high time and period, the capture flag, the sticky
// overflow flag and the clock-running flag.
// Mode, period, compares, one-shot and output enable are written through the
// APB port; the user must write them only while the channel is idle, which
// the block itself does not enforce. Reads return the stored values. The
// channel state and the result register are both updated at the edge that
// accepts the beat, at one beat per cycle while the receiver takes results.
// The result register frees itself when the receiver takes its beat, so a new
// beat is accepted whenever the result register is empty or being drained.
// While the receiver stalls with a result waiting, s_tready is low and the
// channel state holds.
// Synchronous reset clears the counter, the captured values, the flags and the
// output stream, and loads the register reset values.
module timer_counter_pwm_capture_channel #(
  parameter int unsigned COUNT_WIDTH = tcpc_pkg::CountWidthDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [0] capture_level, [7:1] zero
  input  logic [tcpc_pkg::InDataWidth-1:0]  s_tdata,
  // [1:0] opcode
  input  logic [tcpc_pkg::InUserWidth-1:0]  s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [15:0] count_value, [16] wave_a, [17] wave_b, [18] period_match,
  // [34:19] captured_high, [50:35] captured_period, [51] capture_valid,
  // [52] overflow, [53] clock_running, [55:54] zero
  output logic [tcpc_pkg::OutDataWidth-1:0] m_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tcpc_pkg::ApbAddrWidth-1:0] paddr,
  input  logic [tcpc_pkg::ApbDataWidth-1:0] pwdata,
  output logic [tcpc_pkg::ApbDataWidth-1:0] prdata,
  output logic                              pready
);
  import tcpc_pkg::*;

  localparam int unsigned CmpWidth = (COUNT_WIDTH > FieldWidth) ? COUNT_WIDTH : FieldWidth;

  logic [1:0]            mode;
  logic [FieldWidth-1:0] period_top;
  logic [FieldWidth-1:0] compare_a;
  logic [FieldWidth-1:0] compare_b;
  logic                  one_shot;
  logic                  output_enable;

  logic [COUNT_WIDTH-1:0] counter, counter_next;
  logic                   counting_down, counting_down_next;
  logic                   running, running_next;
  logic                   level_a, level_a_next;
  logic                   level_b, level_b_next;
  logic [FieldWidth-1:0]  latched_high, latched_high_next;
  logic [FieldWidth-1:0]  latched_period, latched_period_next;
  logic                   overflow_seen, overflow_seen_next;
  logic                   previous_level;

  logic                   in_beat;
  logic                   cfg_write;
  logic [2:0]             reg_index;
  op_t                    op;
  logic                   lvl, rise, fall, capture;
  logic                   pm, cv;
  logic                   wave_a, wave_b;
  logic [COUNT_WIDTH-1:0] counter_inc;
  logic [CmpWidth-1:0]    cnt_ext, new_ext, top_ext, ca_ext, cb_ext;

  assign pready    = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign in_beat   = s_tvalid && s_tready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= RESET_MODE;
      period_top    <= RESET_PERIOD_TOP;
      compare_a     <= '0;
      compare_b     <= '0;
      one_shot      <= 1'b1;
      output_enable <= 1'b0;
    end else if (cfg_write) begin
      case (reg_index)
        REG_MODE:          mode          <= pwdata[1:0];
        REG_PERIOD_TOP:    period_top    <= pwdata[FieldWidth-1:0];
        REG_COMPARE_A:     compare_a     <= pwdata[FieldWidth-1:0];
        REG_COMPARE_B:     compare_b     <= pwdata[FieldWidth-1:0];
        REG_ONE_SHOT:      one_shot      <= pwdata[0];
        REG_OUTPUT_ENABLE: output_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_MODE:          prdata = ApbDataWidth'(mode);
      REG_PERIOD_TOP:    prdata = ApbDataWidth'(period_top);
      REG_COMPARE_A:     prdata = ApbDataWidth'(compare_a);
      REG_COMPARE_B:     prdata = ApbDataWidth'(compare_b);
      REG_ONE_SHOT:      prdata = ApbDataWidth'(one_shot);
      REG_OUTPUT_ENABLE: prdata = ApbDataWidth'(output_enable);
      default:           prdata = '0;
    endcase
  end

  assign op          = op_t'(s_tuser[1:0]);
  assign lvl         = s_tdata[0];
  assign rise        = lvl && !previous_level;
  assign fall        = !lvl && previous_level;
  assign capture     = mode[1];
  assign counter_inc = counter + COUNT_WIDTH'(1);
  assign cnt_ext     = CmpWidth'(counter);
  assign top_ext     = CmpWidth'(period_top);
  assign ca_ext      = CmpWidth'(compare_a);
  assign cb_ext      = CmpWidth'(compare_b);
  assign new_ext     = CmpWidth'(counter_next);

  always_comb begin
    counter_next        = counter;
    counting_down_next  = counting_down;
    running_next        = running;
    level_a_next        = level_a;
    level_b_next        = level_b;
    latched_high_next   = latched_high;
    latched_period_next = latched_period;
    overflow_seen_next  = overflow_seen;
    pm                  = 1'b0;
    cv                  = 1'b0;

    if (op == OP_CLK_DISABLE) begin
      running_next = 1'b0;
    end
    if (op == OP_CLK_ENABLE) begin
      running_next = 1'b1;
    end

    if (running_next) begin
      if (capture) begin
        if (fall) begin
          latched_high_next = cnt_ext[FieldWidth-1:0];
        end
        if (rise) begin
          latched_period_next = cnt_ext[FieldWidth-1:0];
          counter_next        = '0;
          cv                  = 1'b1;
          if (one_shot) begin
            running_next = 1'b0;
          end
        end else if (op == OP_TRIGGER) begin
          counter_next = '0;
        end else if (op == OP_TICK) begin
          counter_next = counter_inc;
          if (counter_inc == '0) begin
            overflow_seen_next = 1'b1;
          end
        end
      end else if (op == OP_TRIGGER) begin
        counter_next       = '0;
        counting_down_next = 1'b0;
        level_a_next       = compare_a != '0;
        level_b_next       = compare_b != '0;
      end else if (op == OP_TICK) begin
        if (mode == MODE_UP) begin
          counter_next = (cnt_ext == top_ext) ? '0 : counter_inc;
        end else if (period_top == '0) begin
          counter_next       = '0;
          counting_down_next = 1'b0;
        end else begin
          if (!counting_down && cnt_ext >= top_ext) begin
            counting_down_next = 1'b1;
          end else if (counting_down && counter == '0) begin
            counting_down_next = 1'b0;
          end
          if (counting_down_next) begin
            counter_next = (counter == '0) ? '0 : counter - COUNT_WIDTH'(1);
          end else begin
            counter_next = counter_inc;
          end
        end
        if (new_ext == ca_ext) begin
          level_a_next = 1'b0;
        end
        if (new_ext == cb_ext) begin
          level_b_next = 1'b0;
        end
        if (new_ext == top_ext) begin
          pm           = 1'b1;
          level_a_next = 1'b1;
          level_b_next = 1'b1;
        end
        if (compare_a == '0) begin
          level_a_next = 1'b0;
        end
        if (compare_b == '0) begin
          level_b_next = 1'b0;
        end
      end
    end
  end

  assign wave_a = !capture && output_enable && level_a_next;
  assign wave_b = !capture && output_enable && level_b_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter        <= '0;
      counting_down  <= 1'b0;
      running        <= 1'b0;
      level_a        <= 1'b0;
      level_b        <= 1'b0;
      latched_high   <= '0;
      latched_period <= '0;
      overflow_seen  <= 1'b0;
      previous_level <= 1'b0;
    end else if (in_beat) begin
      counter        <= counter_next;
      counting_down  <= counting_down_next;
      running        <= running_next;
      level_a        <= level_a_next;
      level_b        <= level_b_next;
      latched_high   <= latched_high_next;
      latched_period <= latched_period_next;
      overflow_seen  <= overflow_seen_next;
      previous_level <= lvl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_beat) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      m_tdata <= {2'b00, running_next, overflow_seen_next, cv,
                  latched_period_next, latched_high_next, pm, wave_b, wave_a,
                  new_ext[FieldWidth-1:0]};
    end
  end

  assert property (@(posedge clk) disable iff (rst) overflow_seen |=> overflow_seen)
    else $error("overflow flag cleared without reset");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[51]) |-> (m_tdata[15:0] == '0))
    else $error("period capture beat without restarted count");

  assert property (@(posedge clk) disable iff (rst)
    (in_beat && op == OP_CLK_DISABLE) |=> !running)
    else $error("clock still running after disable beat");

  assert property (@(posedge clk) disable iff (rst)
    (in_beat && !running && op == OP_TICK) |=> $stable(counter))
    else $error("counter moved while clock stopped");

endmodule

// ===== tb/timer_counter_pwm_capture_channel_test.sv =====
`timescale 1ns / 1ps

module timer_counter_pwm_capture_channel_test;
  import tcpc_pkg::*;

  // Packed so that the last field sits in the lowest bits, as on m_tdata.
  typedef struct packed {
    logic        clock_running;
    logic        overflow;
    logic        capture_valid;
    logic [15:0] captured_period;
    logic [15:0] captured_high;
    logic        period_match;
    logic        wave_b;
    logic        wave_a;
    logic [15:0] count_value;
  } chan_result_t;

  typedef enum logic { ROW_BEAT, ROW_WRITE } row_kind_t;

  typedef struct {
    row_kind_t    kind;
    op_t          op;
    logic         level;
    logic [2:0]   reg_idx;
    logic [15:0]  value;
    logic         typed;
    chan_result_t result;
  } dir_row_t;

  localparam int DirectedRows = 36;
  localparam chan_result_t ALL_CLEAR = '0;
  localparam chan_result_t ONLY_RUNNING = '{clock_running: 1'b1, default: '0};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // [0] capture_level, [7:1] zero
  logic [InDataWidth-1:0] s_tdata = '0;
  // [1:0] opcode
  logic [InUserWidth-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // [15:0] count_value, [16] wave_a, [17] wave_b, [18] period_match,
  // [34:19] captured_high, [50:35] captured_period, [51] capture_valid,
  // [52] overflow, [53] clock_running, [55:54] zero
  logic [OutDataWidth-1:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ApbAddrWidth-1:0] paddr = '0;
  logic [ApbDataWidth-1:0] pwdata = '0;
  logic [ApbDataWidth-1:0] prdata;
  logic pready;

  // Register copy and channel state of the predictor.
  logic [1:0]  cfg_mode = RESET_MODE;
  logic [15:0] cfg_period = RESET_PERIOD_TOP;
  logic [15:0] cfg_cmp_a = '0;
  logic [15:0] cfg_cmp_b = '0;
  logic        cfg_one_shot = 1'b1;
  logic        cfg_out_en = 1'b0;
  logic [15:0] chan_count = '0;
  logic        chan_down = 1'b0;
  logic        chan_running = 1'b0;
  logic        chan_level_a = 1'b0;
  logic        chan_level_b = 1'b0;
  logic [15:0] chan_high = '0;
  logic [15:0] chan_period = '0;
  logic        chan_overflow = 1'b0;
  logic        chan_prev_level = 1'b0;

  chan_result_t pending_results [$];
  dir_row_t     directed_rows [DirectedRows];
  int           failures = 0;
  logic         no_idle = 1'b0;
  logic         hold_request = 1'b0;
  logic         hold_done = 1'b0;
  int           hold_left = 0;

  timer_counter_pwm_capture_channel DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  function automatic chan_result_t advance_channel(input op_t op, input logic level);
    chan_result_t r;
    logic rise, fall, capture, matched, latched;
    rise = level && !chan_prev_level;
    fall = !level && chan_prev_level;
    capture = cfg_mode >= MODE_CAPTURE;
    matched = 1'b0;
    latched = 1'b0;
    chan_prev_level = level;
    if (op == OP_CLK_DISABLE) chan_running = 1'b0;
    if (op == OP_CLK_ENABLE) chan_running = 1'b1;
    if (chan_running) begin
      if (capture) begin
        if (fall) chan_high = chan_count;
        if (rise) begin
          chan_period = chan_count;
          chan_count = '0;
          latched = 1'b1;
          if (cfg_one_shot) chan_running = 1'b0;
        end else if (op == OP_TRIGGER) begin
          chan_count = '0;
        end else if (op == OP_TICK) begin
          chan_count = chan_count + 16'd1;
          if (chan_count == 16'd0) chan_overflow = 1'b1;
        end
      end else if (op == OP_TRIGGER) begin
        chan_count = '0;
        chan_down = 1'b0;
        chan_level_a = cfg_cmp_a != 16'd0;
        chan_level_b = cfg_cmp_b != 16'd0;
      end else if (op == OP_TICK) begin
        if (cfg_mode == MODE_UP) begin
          chan_count = (chan_count == cfg_period) ? 16'd0 : chan_count + 16'd1;
        end else if (cfg_period == 16'd0) begin
          chan_count = '0;
          chan_down = 1'b0;
        end else begin
          if (!chan_down && chan_count >= cfg_period) chan_down = 1'b1;
          else if (chan_down && chan_count == 16'd0) chan_down = 1'b0;
          if (chan_down) chan_count = (chan_count != 16'd0) ? chan_count - 16'd1 : 16'd0;
          else chan_count = chan_count + 16'd1;
        end
        if (chan_count == cfg_cmp_a) chan_level_a = 1'b0;
        if (chan_count == cfg_cmp_b) chan_level_b = 1'b0;
        if (chan_count == cfg_period) begin
          matched = 1'b1;
          chan_level_a = 1'b1;
          chan_level_b = 1'b1;
        end
        if (cfg_cmp_a == 16'd0) chan_level_a = 1'b0;
        if (cfg_cmp_b == 16'd0) chan_level_b = 1'b0;
      end
    end
    r.count_value     = chan_count;
    r.wave_a          = !capture && cfg_out_en && chan_level_a;
    r.wave_b          = !capture && cfg_out_en && chan_level_b;
    r.period_match    = matched;
    r.captured_high   = chan_high;
    r.captured_period = chan_period;
    r.capture_valid   = latched;
    r.overflow        = chan_overflow;
    r.clock_running   = chan_running;
    return r;
  endfunction

  function automatic dir_row_t beat_row(input op_t op, input logic level);
    return '{ROW_BEAT, op, level, REG_MODE, 16'd0, 1'b0, ALL_CLEAR};
  endfunction

  function automatic dir_row_t typed_row(input op_t op, input logic level,
                                         input chan_result_t result);
    return '{ROW_BEAT, op, level, REG_MODE, 16'd0, 1'b1, result};
  endfunction

  function automatic dir_row_t write_row(input logic [2:0] idx, input logic [15:0] value);
    return '{ROW_WRITE, OP_TICK, 1'b0, idx, value, 1'b0, ALL_CLEAR};
  endfunction

  function automatic logic [15:0] pick_compare(input logic [15:0] top);
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return top;
      default: return 16'($urandom_range(0, (top > 16'd30) ? 30 : int'(top) + 1));
    endcase
  endfunction

  task automatic send_beat(input op_t op, input logic level, input logic typed,
                           input chan_result_t typed_result);
    logic taken;
    chan_result_t predicted;
    while (!no_idle && $urandom_range(0, 99) < 15) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, level};
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
    predicted = advance_channel(op, level);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic settle_channel;
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
    logic ready;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ready = pready;
      @(posedge clk);
    end while (!ready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_MODE:          cfg_mode = value[1:0];
      REG_PERIOD_TOP:    cfg_period = value;
      REG_COMPARE_A:     cfg_cmp_a = value;
      REG_COMPARE_B:     cfg_cmp_b = value;
      REG_ONE_SHOT:      cfg_one_shot = value[0];
      REG_OUTPUT_ENABLE: cfg_out_en = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      m_tready  <= 1'b0;
      hold_done <= 1'b1;
      hold_left <= 80;
    end else begin
      m_tready <= no_idle || ($urandom_range(0, 99) >= 15);
    end
  end

  always @(negedge clk) begin : check_results
    chan_result_t seen;
    chan_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen = m_tdata[53:0];
      if (pending_results.size() == 0) begin
        $error("result beat arrived with nothing expected");
        failures++;
      end else begin
        want = pending_results.pop_front();
        check_field("count_value", want.count_value, seen.count_value);
        check_field("wave_a", want.wave_a, seen.wave_a);
        check_field("wave_b", want.wave_b, seen.wave_b);
        check_field("period_match", want.period_match, seen.period_match);
        check_field("captured_high", want.captured_high, seen.captured_high);
        check_field("captured_period", want.captured_period, seen.captured_period);
        check_field("capture_valid", want.capture_valid, seen.capture_valid);
        check_field("overflow", want.overflow, seen.overflow);
        check_field("clock_running", want.clock_running, seen.clock_running);
      end
    end
  end

  initial begin
    #100000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int          p;
    int          k;
    int          roll;
    op_t         op;
    logic        level;
    logic [15:0] per;
    logic [15:0] ca;
    logic [15:0] cb;

    directed_rows = '{
      typed_row(OP_TICK, 1'b0, ALL_CLEAR),
      typed_row(OP_TRIGGER, 1'b1, ALL_CLEAR),
      write_row(REG_OUTPUT_ENABLE, 16'd1),
      write_row(REG_PERIOD_TOP, 16'd3),
      write_row(REG_COMPARE_A, 16'd3),
      typed_row(OP_CLK_ENABLE, 1'b0, ONLY_RUNNING),
      beat_row(OP_TRIGGER, 1'b0),
      beat_row(OP_TICK, 1'b0),
      beat_row(OP_TICK, 1'b1),
      beat_row(OP_TICK, 1'b0),
      beat_row(OP_TICK, 1'b0),
      beat_row(OP_TICK, 1'b1),
      write_row(REG_MODE, {14'd0, MODE_UPDOWN}),
      write_row(REG_PERIOD_TOP, 16'd2),
      write_row(REG_COMPARE_B, 16'd1),
      beat_row(OP_TICK, 1'b0),
      beat_row(OP_TICK, 1'b0),
      beat_row(OP_TICK, 1'b1),
      beat_row(OP_TICK, 1'b1),
      beat_row(OP_TICK, 1'b0),
      beat_row(OP_TICK, 1'b0),
      write_row(REG_PERIOD_TOP, 16'd0),
      beat_row(OP_TICK, 1'b0),
      beat_row(OP_TICK, 1'b0),
      write_row(REG_MODE, {14'd0, MODE_CAPTURE_ALT}),
      write_row(REG_ONE_SHOT, 16'd0),
      beat_row(OP_TICK, 1'b1),
      beat_row(OP_TICK, 1'b1),
      beat_row(OP_TICK, 1'b0),
      beat_row(OP_TRIGGER, 1'b0),
      beat_row(OP_CLK_DISABLE, 1'b1),
      beat_row(OP_CLK_ENABLE, 1'b0),
      beat_row(OP_TICK, 1'b0),
      write_row(REG_ONE_SHOT, 16'd1),
      beat_row(OP_TICK, 1'b1),
      beat_row(OP_TICK, 1'b0)
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (k = 0; k < DirectedRows; k++) begin
      if (directed_rows[k].kind == ROW_WRITE) begin
        settle_channel();
        write_register(directed_rows[k].reg_idx, directed_rows[k].value);
      end else begin
        send_beat(directed_rows[k].op, directed_rows[k].level, directed_rows[k].typed,
                  directed_rows[k].result);
      end
    end

    level = chan_prev_level;
    for (p = 0; p < 10; p++) begin
      settle_channel();
      no_idle <= (p == 4);
      case (p)
        1: per = 16'd0;
        2: per = 16'hFFFF;
        default: per = 16'($urandom_range(1, 24));
      endcase
      if (p == 2) begin
        ca = 16'hFFFF;
        cb = 16'hFFFE;
      end else begin
        ca = pick_compare(per);
        cb = pick_compare(per);
      end
      write_register(REG_MODE, 16'(p % 4));
      write_register(REG_PERIOD_TOP, per);
      write_register(REG_COMPARE_A, ca);
      write_register(REG_COMPARE_B, cb);
      write_register(REG_ONE_SHOT, 16'($urandom_range(0, 1)));
      write_register(REG_OUTPUT_ENABLE, (p == 3) ? 16'd0 : 16'd1);
      if (p == 6) hold_request <= 1'b1;
      for (k = 0; k < 50; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) op = OP_TICK;
        else if (roll < 80) op = OP_TRIGGER;
        else if (roll < 88) op = OP_CLK_DISABLE;
        else op = OP_CLK_ENABLE;
        if ($urandom_range(0, 99) < 25) level = ~level;
        send_beat(op, level, 1'b0, ALL_CLEAR);
      end
    end

    settle_channel();
    repeat (4) @(posedge clk);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
